// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files of the set cover accumulator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gsc_pkg.sv =====
// shared types and constants of the set cover accumulator
`default_nettype none

package gsc_pkg;

    localparam int ELEMENT_W        = 11;
    localparam int SUBSET_W         = 16;
    localparam int WEIGHT_W         = 16;
    localparam int COUNT_W          = 11;
    localparam int TOTAL_W          = 28;
    localparam int USED_W           = 13;
    localparam int EPOCH_W          = 6;
    localparam int MAX_ELEMENTS_DEF = 1024;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-3:0] REG_ELEMENT_COUNT = '0;

    localparam logic CMD_CLEAR   = 1'b0;
    localparam logic CMD_ELEMENT = 1'b1;

    typedef struct packed {
        logic                command;
        logic [SUBSET_W-1:0] subset_number;
        logic [WEIGHT_W-1:0] subset_weight;
        logic [ELEMENT_W-1:0] element_number;
        logic                last_in_subset;
    } gsc_in_t;

    typedef struct packed {
        logic               newly_covered;
        logic               bad_element;
        logic [COUNT_W-1:0] covered_count;
        logic [TOTAL_W-1:0] total_weight;
        logic [USED_W-1:0]  subsets_used;
        logic               all_covered;
    } gsc_out_t;

    // status of the update stage as seen by the accumulator
    typedef struct packed {
        logic valid;
        logic hit;
    } gsc_stage_t;

endpackage

`default_nettype wire

// ===== rtl/greedy_set_cover_accumulator.sv =====
// top level of the greedy set cover accumulator
`default_nettype none

// Greedy set cover accumulator. Subset members stream in one transaction per element; each
// transaction gives exactly one result transaction, in order, carrying newly_covered,
// bad_element and the running covered count, total weight, subsets used and all_covered.
// Throughput is one transaction per clock while s_ready is high. The covered bitmap is
// a tag memory with a registered read, read when a transaction is taken and written
// back as it leaves the update stage; the last write is forwarded to the following
// element so back-to-back hits on the same element are seen. A registered result stage
// lets a new transaction be taken while the previous result waits. The bitmap stores
// an epoch tag per element, so a clear command passes through like any other transaction.
// After reset, and after every 63rd clear command when the epoch counter wraps, a
// clearing pass over all MAX_ELEMENTS entries zeroes the tag memory; s_ready is low
// during it, the apb register stays writable. element_count is clamped to 1..MAX_ELEMENTS
// and should only be written while no transaction is in flight.

`include "assert_macros.svh"

module greedy_set_cover_accumulator #(
    parameter int MAX_ELEMENTS = gsc_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // element transactions
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire gsc_pkg::gsc_in_t                s_data,
    // result transactions
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output gsc_pkg::gsc_out_t                    m_data,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [gsc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [gsc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [gsc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);

    localparam int ADDR_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W   = (ADDR_W > gsc_pkg::ELEMENT_W) ? ADDR_W : gsc_pkg::ELEMENT_W;
    localparam int EPOCH_W = gsc_pkg::EPOCH_W;

    // epoch and clearing pass
    logic [EPOCH_W-1:0] epoch_reg;
    logic               sweep_reg;
    logic [ADDR_W-1:0]  sweep_addr_reg;

    // update stage
    logic               s1_valid_reg;
    gsc_pkg::gsc_in_t   s1_item_reg;
    logic [EPOCH_W-1:0] s1_epoch_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;

    // last write to the tag memory, forwarded to the element read alongside it
    logic               fwd_valid_reg;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    logic [EPOCH_W-1:0] fwd_epoch_reg;

    logic               s_acc;
    logic               s1_adv;
    logic               advance;
    logic               wr_en;
    logic [IDX_W-1:0]   idx_wide;
    logic [ADDR_W-1:0]  s_addr;
    logic [EPOCH_W-1:0] rd_tag;
    logic               hit;
    logic [CNT_W-1:0]   eff_count;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [EPOCH_W-1:0] ram_wdata;
    gsc_pkg::gsc_stage_t stage;

    assign s_ready = !sweep_reg && (!s1_valid_reg || advance);
    assign s_acc   = s_valid && s_ready;
    assign s1_adv  = s1_valid_reg && advance;

    // one-based element number to memory address
    assign idx_wide = IDX_W'(s_data.element_number) - IDX_W'(1);
    assign s_addr   = idx_wide[ADDR_W-1:0];

    gsc_apb_regs #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .CNT_W        (CNT_W)
    ) u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .eff_count (eff_count)
    );

    // write port: clearing pass or the element marked covered in the update stage
    assign ram_we    = sweep_reg || wr_en;
    assign ram_waddr = sweep_reg ? sweep_addr_reg : s1_addr_reg;
    assign ram_wdata = sweep_reg ? '0 : s1_epoch_reg;

    gsc_tag_ram #(
        .DEPTH  (MAX_ELEMENTS),
        .ADDR_W (ADDR_W),
        .DATA_W (EPOCH_W)
    ) u_tags (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_acc),
        .raddr (s_addr),
        .rdata (rd_tag)
    );

    // covered when the stored tag matches this transaction's epoch
    assign hit = (rd_tag == s1_epoch_reg) ||
                 (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg) &&
                  (fwd_epoch_reg == s1_epoch_reg));

    assign stage.valid = s1_valid_reg;
    assign stage.hit   = hit;

    gsc_accum #(
        .CNT_W        (CNT_W)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .stage     (stage),
        .item      (s1_item_reg),
        .eff_count (eff_count),
        .advance   (advance),
        .wr_en     (wr_en),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // epoch counter and clearing pass control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg      <= EPOCH_W'(1);
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
        end else begin
            if (s_acc && (s_data.command == gsc_pkg::CMD_CLEAR)) begin
                if (epoch_reg == '1) begin
                    // tags would alias after wrap, wipe the memory first
                    epoch_reg      <= EPOCH_W'(1);
                    sweep_reg      <= 1'b1;
                    sweep_addr_reg <= '0;
                end else begin
                    epoch_reg <= epoch_reg + EPOCH_W'(1);
                end
            end
            if (sweep_reg) begin
                sweep_addr_reg <= sweep_addr_reg + ADDR_W'(1);
                if (sweep_addr_reg == ADDR_W'(MAX_ELEMENTS - 1)) begin
                    sweep_reg <= 1'b0;
                end
            end
        end
    end

    // update stage valid and forwarding state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (sweep_reg) begin
                fwd_valid_reg <= 1'b0;
            end else if (s1_adv) begin
                fwd_valid_reg <= wr_en;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_item_reg  <= s_data;
            s1_addr_reg  <= s_addr;
            // a clear runs in the new epoch so its own stage sees no stale match
            if (s_data.command == gsc_pkg::CMD_CLEAR) begin
                s1_epoch_reg <= (epoch_reg == '1) ? EPOCH_W'(1) : epoch_reg + EPOCH_W'(1);
            end else begin
                s1_epoch_reg <= epoch_reg;
            end
        end
        if (s1_adv) begin
            fwd_addr_reg  <= s1_addr_reg;
            fwd_epoch_reg <= s1_epoch_reg;
        end
    end

    `ASSERT_ALWAYS(a_sweep_no_item_write, !(sweep_reg && wr_en),
        "element write collides with clearing pass")
    `ASSERT_NEXT(a_wrap_starts_sweep,
        s_acc && (s_data.command == gsc_pkg::CMD_CLEAR) && (epoch_reg == '1),
        sweep_reg && (epoch_reg == EPOCH_W'(1)),
        "epoch wrap did not start a clearing pass")

endmodule

`default_nettype wire

// ===== rtl/gsc_tag_ram.sv =====
// single port write, single port read tag memory with registered read data
`default_nettype none

module gsc_tag_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 6
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/gsc_apb_regs.sv =====
// apb configuration register with element count clamping
`default_nettype none

module gsc_apb_regs #(
    parameter int MAX_ELEMENTS = gsc_pkg::MAX_ELEMENTS_DEF,
    parameter int CNT_W        = 11
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [gsc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [gsc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [gsc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output logic      [CNT_W-1:0]                eff_count
);

    localparam int REG_W = (CNT_W > gsc_pkg::ELEMENT_W) ? CNT_W : gsc_pkg::ELEMENT_W;

    logic [REG_W-1:0] element_count_reg;
    logic             reg_hit;
    logic             wr_fire;

    assign reg_hit = (paddr[gsc_pkg::APB_ADDR_W-1:2] == gsc_pkg::REG_ELEMENT_COUNT);
    assign wr_fire = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_count_reg <= REG_W'(MAX_ELEMENTS);
        end else if (wr_fire && reg_hit) begin
            element_count_reg <= REG_W'(pwdata[gsc_pkg::ELEMENT_W-1:0]);
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_hit) begin
            prdata = gsc_pkg::APB_DATA_W'(element_count_reg);
        end
    end

    // clamp to 1 .. MAX_ELEMENTS
    always_comb begin
        if (element_count_reg == '0) begin
            eff_count = CNT_W'(1);
        end else if (element_count_reg > REG_W'(MAX_ELEMENTS)) begin
            eff_count = CNT_W'(MAX_ELEMENTS);
        end else begin
            eff_count = CNT_W'(element_count_reg);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gsc_accum.sv =====
// update stage: running totals, subset inclusion and the result register
`default_nettype none

`include "assert_macros.svh"

module gsc_accum #(
    parameter int CNT_W        = 11
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire gsc_pkg::gsc_stage_t stage,
    input  wire gsc_pkg::gsc_in_t    item,
    input  wire logic [CNT_W-1:0]   eff_count,
    output logic                    advance,
    output logic                    wr_en,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output gsc_pkg::gsc_out_t        m_data
);

    localparam int CMP_W = (CNT_W > gsc_pkg::ELEMENT_W) ? CNT_W : gsc_pkg::ELEMENT_W;
    localparam int TW    = gsc_pkg::TOTAL_W;

    logic [CNT_W-1:0]             covered_reg, covered_next;
    logic [TW-1:0]                weight_reg, weight_next;
    logic [gsc_pkg::USED_W-1:0]   used_reg, used_next;
    logic                         incl_reg, incl_next;
    logic                         out_valid_reg;
    gsc_pkg::gsc_out_t            out_reg, result;

    logic        fire;
    logic        done;
    logic        bad;
    logic        newly;
    logic [TW:0] weight_sum;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = stage.valid && advance;

    assign done = (covered_reg >= eff_count);
    assign bad  = (item.element_number == '0) ||
                  (CMP_W'(item.element_number) > CMP_W'(eff_count));
    assign weight_sum = {1'b0, weight_reg} + (TW+1)'(item.subset_weight);

    always_comb begin
        covered_next = covered_reg;
        weight_next  = weight_reg;
        used_next    = used_reg;
        incl_next    = incl_reg;
        newly        = 1'b0;
        if (item.command == gsc_pkg::CMD_CLEAR) begin
            covered_next = '0;
            weight_next  = '0;
            used_next    = '0;
            incl_next    = 1'b0;
        end else begin
            if (!bad && !done && !stage.hit) begin
                newly        = 1'b1;
                covered_next = covered_reg + CNT_W'(1);
                // first new element of this subset pays its weight
                if (!incl_reg) begin
                    incl_next = 1'b1;
                    if (weight_sum[TW]) begin
                        weight_next = '1;
                    end else begin
                        weight_next = weight_sum[TW-1:0];
                    end
                    if (used_reg != '1) begin
                        used_next = used_reg + gsc_pkg::USED_W'(1);
                    end
                end
            end
            if (item.last_in_subset) begin
                incl_next = 1'b0;
            end
        end
    end

    always_comb begin
        result.newly_covered = newly;
        result.bad_element   = (item.command == gsc_pkg::CMD_ELEMENT) && bad;
        result.covered_count = gsc_pkg::COUNT_W'(covered_next);
        result.total_weight  = weight_next;
        result.subsets_used  = used_next;
        result.all_covered   = (item.command == gsc_pkg::CMD_ELEMENT) &&
                               (covered_next >= eff_count);
    end

    assign wr_en = fire && newly;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            covered_reg   <= '0;
            weight_reg    <= '0;
            used_reg      <= '0;
            incl_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                covered_reg <= covered_next;
                weight_reg  <= weight_next;
                used_reg    <= used_next;
                incl_reg    <= incl_next;
            end
            if (advance) begin
                out_valid_reg <= stage.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `ASSERT_IMPLIES(a_newly_not_bad, out_valid_reg && out_reg.newly_covered,
        !out_reg.bad_element, "newly covered element flagged as bad")
    `ASSERT_NEXT(a_cover_step, fire,
        (covered_reg == $past(covered_reg)) ||
        (covered_reg == $past(covered_reg) + CNT_W'(1)) || (covered_reg == '0),
        "covered count moved by more than one")

endmodule

`default_nettype wire
